[hdl/pwmt_pkg.sv]
// pwmt_pkg: shared types and constants for the pulse width message transmitter
// queue sizing, encoder phase codes, register indexes, front-to-back command and result records
// no dependencies
`timescale 1ns / 1ps

package pwmt_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QF_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 9;
    localparam int END_MARK_BIT = 8;
    localparam int LEN_W       = 8;
    localparam int BIT_IDX_W   = 4;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LEN   = 3'd4;

    typedef enum logic [2:0] {
        PH_START_HIGH = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_MSG_HIGH   = 3'd2,
        PH_MSG_LOW    = 3'd3,
        PH_STOP_LOW   = 3'd4,
        PH_STOP_HIGH  = 3'd5,
        PH_IDLE       = 3'd6
    } t_phase;

    typedef struct packed {
        logic       is_push;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_cmd;

    typedef struct packed {
        logic push_rejected;
        logic busy_res;
        logic line_level;
    } t_result;

endpackage

[hdl/pwmt_ram.sv]
// pwmt_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pwmt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pwmt_front.sv]
// pwmt_front: accepts stream beats, classifies them as push or tick, holds them in a
// two entry command queue for the encoder back end
// depends on pwmt_pkg
`timescale 1ns / 1ps

module pwmt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_data,
    input  logic            i_in_kind,
    input  logic            i_in_last,
    output logic            o_cmd_valid,
    output pwmt_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);

    pwmt_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;
    logic           in_fire;
    logic           pop_fire;
    pwmt_pkg::t_cmd in_cmd;

    assign o_in_ready  = (r_count != 2'd2);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop_fire    = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        in_cmd.is_push        = i_in_kind;
        in_cmd.data_byte      = i_in_data;
        in_cmd.end_of_message = i_in_last;
    end

    always_comb begin
        n_wr_ptr = in_fire  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_fire ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (in_fire && !pop_fire) begin
            n_count = r_count + 2'd1;
        end else if (!in_fire && pop_fire) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

[hdl/pwmt_engine.sv]
// pwmt_engine: byte queue and pulse length line encoder, one command per cycle while the
// output register is free or being read; result held in an output register
// depends on pwmt_pkg and pwmt_ram
`timescale 1ns / 1ps

module pwmt_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwmt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pwmt_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                           i_cmd_valid,
    input  pwmt_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_res_valid,
    output pwmt_pkg::t_result              o_res,
    input  logic                           i_res_ready
);

    localparam int QA_W  = pwmt_pkg::QA_W;
    localparam int QF_W  = pwmt_pkg::QF_W;
    localparam int EW    = pwmt_pkg::ENTRY_W;
    localparam int LW    = pwmt_pkg::LEN_W;
    localparam int BW    = pwmt_pkg::BIT_IDX_W;

    function automatic logic [QA_W-1:0] next_slot(input logic [QA_W-1:0] p);
        next_slot = (p == QA_W'(pwmt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [LW-1:0] r_start_len, r_zero_len, r_one_len, r_stop_len, r_gap_len;

    logic [QA_W-1:0]  r_head, n_head;
    logic [QA_W-1:0]  r_tail, n_tail;
    logic [QF_W-1:0]  r_fill, n_fill;
    logic [BW-1:0]    r_bit, n_bit;
    pwmt_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]    r_hold, n_hold;
    logic             r_enabled, n_enabled;
    logic             r_level, n_level;
    // copies of the entries at head and head+1
    logic [EW-1:0]    r_e0, n_e0;
    logic [EW-1:0]    r_e1, n_e1;
    logic             r_rd_pend, n_rd_pend;
    logic             r_out_valid;
    pwmt_pkg::t_result r_out;

    logic             fire;
    logic             rejected;
    logic             ram_we;
    logic             ram_re;
    logic [QA_W-1:0]  head_p1;
    logic [QA_W-1:0]  head_p2;
    logic [EW-1:0]    new_entry;
    logic [EW-1:0]    ram_rdata;

    assign fire      = i_cmd_valid && (!r_out_valid || i_res_ready);
    assign o_cmd_pop = fire;
    assign head_p1   = next_slot(r_head);
    assign head_p2   = next_slot(head_p1);
    assign new_entry = {i_cmd.end_of_message, i_cmd.data_byte};

    pwmt_ram #(
        .WIDTH (EW),
        .DEPTH (pwmt_pkg::QUEUE_DEPTH)
    ) u_byte_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (new_entry),
        .i_re    (ram_re),
        .i_raddr (head_p2),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic bit_val;
        bit_val   = 1'b0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_bit     = r_bit;
        n_phase   = r_phase;
        n_hold    = r_hold;
        n_enabled = r_enabled;
        n_level   = r_level;
        n_e0      = r_e0;
        n_e1      = r_e1;
        n_rd_pend = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        rejected  = 1'b0;

        // refill of the second copy after a pop; a push to that slot overrides it below
        if (r_rd_pend) begin
            n_e1 = ram_rdata;
        end

        if (fire) begin
            if (i_cmd.is_push) begin
                n_enabled = 1'b1;
                if (r_fill == QF_W'(pwmt_pkg::QUEUE_DEPTH)) begin
                    rejected = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    n_tail = next_slot(r_tail);
                    n_fill = r_fill + 1'b1;
                    if (r_fill == '0) begin
                        n_e0 = new_entry;
                    end else if (r_fill == QF_W'(1)) begin
                        n_e1 = new_entry;
                    end
                end
            end else if (r_enabled) begin
                if (r_hold > LW'(1)) begin
                    n_hold = r_hold - 1'b1;
                end else begin
                    unique case (r_phase)
                        pwmt_pkg::PH_START_HIGH: begin
                            n_level = 1'b1;
                            n_hold  = r_start_len;
                            n_phase = pwmt_pkg::PH_START_LOW;
                        end
                        pwmt_pkg::PH_START_LOW: begin
                            n_level = 1'b0;
                            n_hold  = r_start_len;
                            n_phase = pwmt_pkg::PH_MSG_HIGH;
                            n_bit   = '0;
                        end
                        pwmt_pkg::PH_MSG_HIGH: begin
                            if (r_fill == '0) begin
                                n_level = 1'b0;
                                n_phase = pwmt_pkg::PH_STOP_LOW;
                            end else if (r_bit > pwmt_pkg::LAST_BIT) begin
                                // byte done: drop it and move on to the next one
                                n_head    = head_p1;
                                n_fill    = r_fill - 1'b1;
                                n_e0      = r_e1;
                                ram_re    = 1'b1;
                                n_rd_pend = 1'b1;
                                if (r_e0[pwmt_pkg::END_MARK_BIT] || r_fill == QF_W'(1)) begin
                                    n_bit   = '0;
                                    n_level = 1'b0;
                                    n_phase = pwmt_pkg::PH_STOP_LOW;
                                end else begin
                                    n_bit   = BW'(1);
                                    n_level = 1'b1;
                                    n_hold  = r_e1[0] ? r_one_len : r_zero_len;
                                    n_phase = pwmt_pkg::PH_MSG_LOW;
                                end
                            end else begin
                                bit_val = r_e0[r_bit[2:0]];
                                n_bit   = r_bit + 1'b1;
                                n_level = 1'b1;
                                n_hold  = bit_val ? r_one_len : r_zero_len;
                                n_phase = pwmt_pkg::PH_MSG_LOW;
                            end
                        end
                        pwmt_pkg::PH_MSG_LOW: begin
                            n_level = 1'b0;
                            n_phase = pwmt_pkg::PH_MSG_HIGH;
                        end
                        pwmt_pkg::PH_STOP_LOW: begin
                            n_level = 1'b0;
                            n_hold  = r_stop_len;
                            n_phase = pwmt_pkg::PH_STOP_HIGH;
                        end
                        pwmt_pkg::PH_STOP_HIGH: begin
                            n_level = 1'b1;
                            n_hold  = r_stop_len;
                            n_phase = pwmt_pkg::PH_IDLE;
                        end
                        default: begin
                            // idle: start the next frame after a gap, or shut down
                            n_level = 1'b0;
                            n_phase = pwmt_pkg::PH_IDLE;
                            if (r_fill == '0) begin
                                n_enabled = 1'b0;
                            end else begin
                                n_hold  = r_gap_len;
                                n_bit   = '0;
                                n_phase = pwmt_pkg::PH_START_HIGH;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_bit       <= '0;
            r_phase     <= pwmt_pkg::PH_START_HIGH;
            r_hold      <= LW'(1);
            r_enabled   <= 1'b0;
            r_level     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_bit     <= n_bit;
            r_phase   <= n_phase;
            r_hold    <= n_hold;
            r_enabled <= n_enabled;
            r_level   <= n_level;
            r_rd_pend <= n_rd_pend;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= n_e0;
        r_e1 <= n_e1;
        if (fire) begin
            r_out.line_level    <= n_level;
            r_out.busy_res      <= n_enabled;
            r_out.push_rejected <= rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_len <= LW'(8);
            r_zero_len  <= LW'(1);
            r_one_len   <= LW'(3);
            r_stop_len  <= LW'(8);
            r_gap_len   <= LW'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwmt_pkg::CFG_START_LEN: r_start_len <= i_cfg_data;
                pwmt_pkg::CFG_ZERO_LEN:  r_zero_len  <= i_cfg_data;
                pwmt_pkg::CFG_ONE_LEN:   r_one_len   <= i_cfg_data;
                pwmt_pkg::CFG_STOP_LEN:  r_stop_len  <= i_cfg_data;
                pwmt_pkg::CFG_GAP_LEN:   r_gap_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[hdl/pulse_width_message_transmitter_core.sv]
// pulse_width_message_transmitter_core: on/off keyed pulse width message transmitter
//
// input stream: each beat is a push (tuser 1) of a message byte in tdata, with tlast
// marking the last byte of a message, or a time tick (tuser 0) that advances the
// line encoder by one tick. every input beat yields exactly one result beat on the
// output stream: line level, busy flag and a push rejected flag (queue full).
// a frame is start high, start low, each bit lsb first as a high pulse of zero_len
// or one_len ticks plus one low tick, then stop low and stop high; queued messages
// are separated by a low gap of gap_len ticks.
// result path: an accepted input beat waits in the two entry command queue, then its result
// beat is registered in the output register once the encoder takes the command.
// throughput: one beat per cycle when unstalled; the byte queue ram is read only when a
// byte is retired, and retirements are many ticks apart, so its read latency never stalls.
// receiver stall: the output register holds its beat, the two entry command queue
// fills, then s_axis_tready drops; no beat is lost.
// reset (i_rst_n low, synchronous) empties the queue and restores register defaults
// (start 8, zero 1, one 3, stop 8, gap 10); the queue ram needs no clearing pass.
// configuration: i_cfg_we with index 0..4 = start, zero, one, stop, gap length; the user
// must write them only while the block is idle, the block itself does not enforce it.
// depends on pwmt_pkg, pwmt_front, pwmt_engine, pwmt_ram
`timescale 1ns / 1ps

module pulse_width_message_transmitter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwmt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pwmt_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] cmd
    input  logic                           s_axis_tlast,   // end_of_message
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata    // [0] line_level, [1] busy_res,
                                                           // [2] push_rejected, rest zero
);

    logic              cmd_valid;
    pwmt_pkg::t_cmd    cmd;
    logic              cmd_pop;
    pwmt_pkg::t_result res;

    pwmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    pwmt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, res.push_rejected, res.busy_res, res.line_level};

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for pulse_width_message_transmitter_core
// a directed table, then randomized phases under several register settings; each result beat
// is checked against its table row or the in-bench line encoder model. depends on pwmt_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    // result patterns, bits are {push_rejected, busy_res, line_level}
    localparam pwmt_pkg::t_result R_IDLE      = 3'b000;
    localparam pwmt_pkg::t_result R_BUSY_LOW  = 3'b010;
    localparam pwmt_pkg::t_result R_BUSY_HIGH = 3'b011;

    localparam int RESET_CYCLES    = 5;
    localparam int DRAIN_PAD       = 8;
    localparam int SETTLE_TICKS    = 40;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_AT     = 400;
    localparam int PRESSURE_CYCLES = 500;
    localparam int REPORT_CAP      = 40;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        data;
        logic              eom;
        logic              typed;
        pwmt_pkg::t_result want;
    } t_dir_row;

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CMD_TICK, 8'h00, 1'b0, 1'b1, R_IDLE},      // tick before anything is queued
        '{CMD_TICK, 8'hFF, 1'b1, 1'b1, R_IDLE},      // payload ignored on a tick
        '{CMD_PUSH, 8'h00, 1'b0, 1'b1, R_BUSY_LOW},  // first push enables the encoder
        '{CMD_PUSH, 8'hFF, 1'b1, 1'b1, R_BUSY_LOW},
        '{CMD_TICK, 8'h00, 1'b0, 1'b1, R_BUSY_HIGH}, // first frame starts without a gap
        '{CMD_TICK, 8'hFF, 1'b0, 1'b1, R_BUSY_HIGH},
        '{CMD_PUSH, 8'hA5, 1'b0, 1'b0, R_IDLE},
        '{CMD_PUSH, 8'h5A, 1'b1, 1'b0, R_IDLE},
        '{CMD_PUSH, 8'h81, 1'b0, 1'b0, R_IDLE},      // no end mark: ends when the queue runs dry
        '{CMD_TICK, 8'h00, 1'b1, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h55, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'hAA, 1'b1, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h00, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'hFF, 1'b1, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h0F, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'hF0, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h00, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h00, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h00, 1'b0, 1'b0, R_IDLE},
        '{CMD_TICK, 8'h00, 1'b0, 1'b0, R_IDLE}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pwmt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pwmt_pkg::LEN_W-1:0]     i_cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;   // [7:0] data_byte
    logic                           s_axis_tuser = 1'b0; // [0] cmd
    logic                           s_axis_tlast = 1'b0; // end_of_message
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;        // [0] line_level, [1] busy_res,
                                                         // [2] push_rejected

    pulse_width_message_transmitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // encoder model state
    logic [pwmt_pkg::ENTRY_W-1:0]   q_mem [pwmt_pkg::QUEUE_DEPTH];
    int unsigned                    q_head, q_tail, q_fill;
    logic [pwmt_pkg::BIT_IDX_W-1:0] bit_pos;
    pwmt_pkg::t_phase               enc_phase;
    logic [pwmt_pkg::LEN_W-1:0]     hold_cnt;
    logic                           enc_on, line_lvl;
    logic [pwmt_pkg::LEN_W-1:0]     len_start, len_zero, len_one, len_stop, len_gap;

    pwmt_pkg::t_result pending_results [$];
    int      mismatch_count = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;
    int      send_calm = 0;
    int      recv_calm = 0;
    bit      pressure_done = 1'b0;

    // 0 or 1 for the next bit of the message, 2 once the message is done
    function automatic int take_bit();
        logic [pwmt_pkg::ENTRY_W-1:0] entry;
        int                           b;
        if (q_fill == 0) return 2;
        if (bit_pos > pwmt_pkg::LAST_BIT) begin
            entry   = q_mem[q_head];
            q_head  = (q_head + 1) % pwmt_pkg::QUEUE_DEPTH;
            q_fill  = q_fill - 1;
            bit_pos = '0;
            if (entry[pwmt_pkg::END_MARK_BIT] || q_fill == 0) return 2;
        end
        entry   = q_mem[q_head];
        b       = int'(entry[bit_pos[2:0]]);
        bit_pos = bit_pos + 1'b1;
        return b;
    endfunction

    function automatic void advance_phase();
        int b;
        case (enc_phase)
            pwmt_pkg::PH_START_HIGH: begin
                line_lvl = 1'b1; hold_cnt = len_start; enc_phase = pwmt_pkg::PH_START_LOW;
            end
            pwmt_pkg::PH_START_LOW: begin
                line_lvl = 1'b0; hold_cnt = len_start; enc_phase = pwmt_pkg::PH_MSG_HIGH;
                bit_pos = '0;
            end
            pwmt_pkg::PH_MSG_HIGH: begin
                b = take_bit();
                if (b == 2) begin
                    line_lvl = 1'b0; enc_phase = pwmt_pkg::PH_STOP_LOW;
                end else begin
                    line_lvl = 1'b1; hold_cnt = (b == 1) ? len_one : len_zero;
                    enc_phase = pwmt_pkg::PH_MSG_LOW;
                end
            end
            pwmt_pkg::PH_MSG_LOW: begin
                line_lvl = 1'b0; enc_phase = pwmt_pkg::PH_MSG_HIGH;
            end
            pwmt_pkg::PH_STOP_LOW: begin
                line_lvl = 1'b0; hold_cnt = len_stop; enc_phase = pwmt_pkg::PH_STOP_HIGH;
            end
            pwmt_pkg::PH_STOP_HIGH: begin
                line_lvl = 1'b1; hold_cnt = len_stop; enc_phase = pwmt_pkg::PH_IDLE;
            end
            default: begin
                line_lvl = 1'b0; enc_phase = pwmt_pkg::PH_IDLE;
                if (q_fill == 0) begin
                    enc_on = 1'b0;
                end else begin
                    // another message waits: low gap, then a new start
                    hold_cnt = len_gap; bit_pos = '0; enc_phase = pwmt_pkg::PH_START_HIGH;
                end
            end
        endcase
    endfunction

    function automatic pwmt_pkg::t_result encode_item(pwmt_pkg::t_cmd c);
        pwmt_pkg::t_result r;
        r = R_IDLE;
        if (c.is_push) begin
            enc_on = 1'b1;
            if (q_fill >= pwmt_pkg::QUEUE_DEPTH) begin
                r.push_rejected = 1'b1;
            end else begin
                q_mem[q_tail] = {c.end_of_message, c.data_byte};
                q_tail        = (q_tail + 1) % pwmt_pkg::QUEUE_DEPTH;
                q_fill        = q_fill + 1;
            end
        end else if (enc_on) begin
            // a zero length counts as one tick
            if (hold_cnt <= 1) advance_phase();
            else hold_cnt = hold_cnt - 1'b1;
        end
        r.line_level = line_lvl;
        r.busy_res   = enc_on;
        return r;
    endfunction

    // mostly back to back, some short gaps, rare long ones, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // entered just after an accept edge (or from idle); valid stays up when no gap is chosen
    task automatic send_beat(input logic cmd, input logic [7:0] b, input logic e,
                             input logic typed, input pwmt_pkg::t_result want);
        int                g;
        pwmt_pkg::t_cmd    c;
        pwmt_pkg::t_result predicted;
        g = pick_gap(send_calm);
        c.is_push        = cmd;
        c.data_byte      = b;
        c.end_of_message = e;
        @(negedge i_clk);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        s_axis_tlast  <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = encode_item(c);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                  R_IDLE);
    endtask

    // tick toward idle for a bounded stretch, then let every result beat drain
    task automatic settle();
        int n;
        n = 0;
        while (enc_on && n < SETTLE_TICKS) begin
            send_tick();
            n++;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] st, input logic [7:0] zr,
                               input logic [7:0] on, input logic [7:0] sp,
                               input logic [7:0] gp);
        logic [7:0]                     vals [5];
        logic [pwmt_pkg::CFG_IDX_W-1:0] idxs [5];
        int                             k;
        vals = '{st, zr, on, sp, gp};
        idxs = '{pwmt_pkg::CFG_START_LEN, pwmt_pkg::CFG_ZERO_LEN, pwmt_pkg::CFG_ONE_LEN,
                 pwmt_pkg::CFG_STOP_LEN, pwmt_pkg::CFG_GAP_LEN};
        for (k = 0; k < 5; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        len_start = st; len_zero = zr; len_one = on; len_stop = sp; len_gap = gp;
    endtask

    // messages of random bytes between runs of ticks; a few lack the end mark
    // or carry a stray one mid message
    task automatic run_random(input int budget, input int max_msg, input int push_pct);
        int         done;
        int         n;
        int         k;
        logic       eom;
        logic [7:0] b;
        logic       go_push;
        done = 0;
        while (done < budget) begin
            go_push = enc_on ? ($urandom_range(0, 99) < push_pct) : ($urandom_range(0, 4) != 0);
            if (go_push) begin
                n = $urandom_range(1, max_msg);
                for (k = 0; k < n; k++) begin
                    b   = 8'($urandom_range(0, 255));
                    eom = (k == n - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
                    send_beat(CMD_PUSH, b, eom, 1'b0, R_IDLE);
                    done++;
                end
            end else begin
                if (enc_on) done++;
                send_tick();
            end
        end
    endtask

    initial begin : stimulus
        int       r;
        t_dir_row row;
        q_head = 0; q_tail = 0; q_fill = 0;
        bit_pos = '0; enc_phase = pwmt_pkg::PH_START_HIGH; hold_cnt = 8'd1;
        enc_on = 1'b0; line_lvl = 1'b0;
        len_start = 8'd8; len_zero = 8'd1; len_one = 8'd3; len_stop = 8'd8; len_gap = 8'd10;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            send_beat(row.cmd, row.data, row.eom, row.typed, row.want);
        end
        settle();

        load_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        run_random(250, 4, 6);
        settle();

        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random(150, 3, 6);
        settle();

        load_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)));
        run_random(200, 5, 4);
        settle();

        load_config(8'd255, 8'd1, 8'd255, 8'd1, 8'd255);
        run_random(60, 2, 2);
        settle();

        load_config(8'd1, 8'd255, 8'd1, 8'd255, 8'd1);
        run_random(60, 2, 2);
        settle();

        load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        run_random(40, 2, 2);
        settle();

        load_config(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                    8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                    8'($urandom_range(1, 12)));
        run_random(200, 4, 4);
        settle();

        // fill the queue past its depth so the last pushes get rejected
        load_config(8'd1, 8'd2, 8'd1, 8'd1, 8'd1);
        for (r = 0; r < pwmt_pkg::QUEUE_DEPTH + 4; r++)
            send_beat(CMD_PUSH, 8'($urandom_range(0, 255)), ($urandom_range(0, 31) == 0),
                      1'b0, R_IDLE);
        run_random(150, 3, 3);
        settle();

        load_config(8'($urandom_range(1, 32)), 8'($urandom_range(1, 32)),
                    8'($urandom_range(1, 32)), 8'($urandom_range(1, 32)),
                    8'($urandom_range(1, 32)));
        run_random(100, 3, 3);
        settle();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("pulse_width_message_transmitter_core regression: pass");
        else
            $display("pulse_width_message_transmitter_core regression: fail");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off so the core backs up into its input
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        pwmt_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", int'(m_axis_tdata), 0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_axis_tdata[0] !== want.line_level)
                    report_mismatch("line_level", int'(m_axis_tdata[0]),
                                    int'(want.line_level));
                if (m_axis_tdata[1] !== want.busy_res)
                    report_mismatch("busy_res", int'(m_axis_tdata[1]), int'(want.busy_res));
                if (m_axis_tdata[2] !== want.push_rejected)
                    report_mismatch("push_rejected", int'(m_axis_tdata[2]),
                                    int'(want.push_rejected));
                if (m_axis_tdata[7:3] !== 5'd0)
                    report_mismatch("tdata pad bits", int'(m_axis_tdata[7:3]), 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("pulse_width_message_transmitter_core regression: fail");
                $finish;
            end
        end
    end

endmodule
